>>> rtl/core/snpcr_pkg.sv
`default_nettype none

package snpcr_pkg;

    localparam int unsigned ADDR_BITS  = 24;
    localparam int unsigned LEN_BITS   = 17;
    localparam int unsigned CRC_BITS   = 32;
    localparam int unsigned BYTE_BITS  = 8;

    localparam logic [LEN_BITS-1:0]  MAX_LEN       = 17'h10000;
    localparam logic [LEN_BITS-1:0]  PAGE_RESET    = 17'd4096;
    localparam logic [LEN_BITS-1:0]  CHUNK_RESET   = 17'd128;
    localparam logic [CRC_BITS-1:0]  CRC_POLY_REFL = 32'hEDB88320;
    localparam logic [CRC_BITS-1:0]  CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [CRC_BITS-1:0]  CRC_XOROUT    = 32'hFFFFFFFF;
    localparam logic [BYTE_BITS-1:0] CMD_READ      = 8'h03;
    localparam logic [BYTE_BITS-1:0] DUMMY_BYTE    = 8'hFF;

    // Configuration register indexes.
    localparam logic CFG_PAGE_BYTES  = 1'b0;
    localparam logic CFG_CHUNK_BYTES = 1'b1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_RX    = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_XCHG    = 2'd0,
        ACT_CS_HIGH = 2'd1,
        ACT_DONE    = 2'd2
    } t_action;

    typedef struct packed {
        logic                 opcode;
        logic [ADDR_BITS-1:0] page_address;
        logic [BYTE_BITS-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           action;
        logic [BYTE_BITS-1:0] tx_byte;
        logic [CRC_BITS-1:0]  crc_result;
        logic                 last;
    } t_out_item;

    // Reflected CRC-32 update for one byte, LSB first.
    function automatic logic [CRC_BITS-1:0] crc_byte(
        input logic [CRC_BITS-1:0]  crc_in,
        input logic [BYTE_BITS-1:0] data
    );
        logic [CRC_BITS-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < BYTE_BITS; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Zero reads as one, anything above the maximum length saturates.
    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS-1:0] r;
        if (v == '0) begin
            r = {{(LEN_BITS-1){1'b0}}, 1'b1};
        end else if (v > MAX_LEN) begin
            r = MAX_LEN;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/spi_nor_page_crc32_reader.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ------------------------------
// request   in         i_in_valid / o_in_ready     i_in_item  (snpcr_pkg::t_in_item)
// result    out        o_out_valid / i_out_ready   o_out_item (snpcr_pkg::t_out_item)
// config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_wdata
//
// Each request is handled in the cycle it is accepted: the sequencer state is updated
// and the results it causes (none, one or two) go into a four-entry result queue.
// A new request is taken every cycle while the queue has two free entries. A request
// that causes two results (a chunk end) writes both at once, and they leave the result
// port one after the other. Results are registered in the queue and appear once the
// entries ahead of them have left. Reset (synchronous, active low) empties the queue,
// returns the sequencer to idle and loads the default page and chunk lengths.
module spi_nor_page_crc32_reader (
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  snpcr_pkg::t_in_item   i_in_item,

    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output snpcr_pkg::t_out_item  o_out_item,

    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire [snpcr_pkg::LEN_BITS-1:0] i_cfg_wdata
);

    // Sequencer phases. The read command is sent on entry to the header phase, which
    // covers the three address bytes and one dummy exchange; the data phase the rest.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR   = 2;
    localparam int unsigned QCNT   = 3;

    // Configuration, stored already clamped to the legal range.
    logic [snpcr_pkg::LEN_BITS-1:0]  r_page_bytes;
    logic [snpcr_pkg::LEN_BITS-1:0]  r_chunk_bytes;

    // Sequencer state.
    t_phase                          r_phase,      n_phase;
    logic [snpcr_pkg::ADDR_BITS-1:0] r_base,       n_base;
    logic [snpcr_pkg::LEN_BITS-1:0]  r_offset,     n_offset;
    logic [snpcr_pkg::LEN_BITS-1:0]  r_chunk_rem,  n_chunk_rem;
    logic [1:0]                      r_hdr_idx,    n_hdr_idx;
    logic [snpcr_pkg::CRC_BITS-1:0]  r_crc,        n_crc;

    // Result queue.
    snpcr_pkg::t_out_item            r_queue [QDEPTH];
    logic [QPTR-1:0]                 r_wr_ptr;
    logic [QPTR-1:0]                 r_rd_ptr;
    logic [QCNT-1:0]                 r_count;

    logic                            in_fire;
    logic                            out_fire;
    logic [1:0]                      push_cnt;
    snpcr_pkg::t_out_item            res0;
    snpcr_pkg::t_out_item            res1;

    logic [snpcr_pkg::ADDR_BITS-1:0] flash_addr;
    logic [snpcr_pkg::CRC_BITS-1:0]  crc_upd;
    logic [snpcr_pkg::LEN_BITS-1:0]  off_inc;
    logic [snpcr_pkg::LEN_BITS-1:0]  rem_dec;
    logic [snpcr_pkg::LEN_BITS-1:0]  left_bytes;

    // The queue must hold both results of a chunk end, so two free entries are needed.
    assign o_in_ready  = (r_count <= QCNT'(QDEPTH - 2));
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_queue[r_rd_ptr];
    assign out_fire    = o_out_valid && i_out_ready;

    // Address of the current chunk, wrapped to the flash address width.
    assign flash_addr = r_base + snpcr_pkg::ADDR_BITS'(r_offset);
    assign crc_upd    = snpcr_pkg::crc_byte(r_crc, i_in_item.rx_byte);
    assign off_inc    = (r_offset < snpcr_pkg::MAX_LEN) ? r_offset + 1'b1 : r_offset;
    assign rem_dec    = (r_chunk_rem != '0) ? r_chunk_rem - 1'b1 : r_chunk_rem;
    assign left_bytes = (off_inc < r_page_bytes) ? r_page_bytes - off_inc
                                                 : {{(snpcr_pkg::LEN_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase     = r_phase;
        n_base      = r_base;
        n_offset    = r_offset;
        n_chunk_rem = r_chunk_rem;
        n_hdr_idx   = r_hdr_idx;
        n_crc       = r_crc;
        push_cnt    = 2'd0;
        res0        = '{action: snpcr_pkg::ACT_XCHG, tx_byte: snpcr_pkg::CMD_READ,
                        crc_result: '0, last: 1'b1};
        res1        = '{action: snpcr_pkg::ACT_XCHG, tx_byte: snpcr_pkg::CMD_READ,
                        crc_result: '0, last: 1'b1};

        if (in_fire) begin
            if (i_in_item.opcode == snpcr_pkg::OP_START) begin
                // A start while a page is in progress is dropped.
                if (r_phase == PH_IDLE) begin
                    n_base      = i_in_item.page_address;
                    n_offset    = '0;
                    n_crc       = snpcr_pkg::CRC_INIT;
                    n_chunk_rem = (r_page_bytes < r_chunk_bytes) ? r_page_bytes
                                                                 : r_chunk_bytes;
                    n_hdr_idx   = 2'd0;
                    n_phase     = PH_HEADER;
                    push_cnt    = 2'd1;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        push_cnt = 2'd1;
                        case (r_hdr_idx)
                            2'd0: begin
                                res0.tx_byte = flash_addr[23:16];
                            end
                            2'd1: begin
                                res0.tx_byte = flash_addr[15:8];
                            end
                            2'd2: begin
                                res0.tx_byte = flash_addr[7:0];
                            end
                            default: begin
                                res0.tx_byte = snpcr_pkg::DUMMY_BYTE;
                            end
                        endcase
                        if (r_hdr_idx == 2'd3) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 2'd1;
                        end
                    end
                    PH_DATA: begin
                        n_crc       = crc_upd;
                        n_offset    = off_inc;
                        n_chunk_rem = rem_dec;
                        if (rem_dec != '0) begin
                            push_cnt     = 2'd1;
                            res0.tx_byte = snpcr_pkg::DUMMY_BYTE;
                        end else begin
                            // Chunk end: raise chip select, then finish or reopen.
                            push_cnt = 2'd2;
                            res0     = '{action: snpcr_pkg::ACT_CS_HIGH, tx_byte: '0,
                                         crc_result: '0, last: 1'b0};
                            n_hdr_idx = 2'd0;
                            if (off_inc >= r_page_bytes) begin
                                res1    = '{action: snpcr_pkg::ACT_DONE, tx_byte: '0,
                                            crc_result: crc_upd ^ snpcr_pkg::CRC_XOROUT,
                                            last: 1'b1};
                                n_phase = PH_IDLE;
                            end else begin
                                n_chunk_rem = (left_bytes < r_chunk_bytes) ? left_bytes
                                                                           : r_chunk_bytes;
                                n_phase     = PH_HEADER;
                            end
                        end
                    end
                    default: begin
                        // Received bytes while idle are dropped.
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes  <= snpcr_pkg::PAGE_RESET;
            r_chunk_bytes <= snpcr_pkg::CHUNK_RESET;
            r_phase       <= PH_IDLE;
            r_base        <= '0;
            r_offset      <= '0;
            r_chunk_rem   <= '0;
            r_hdr_idx     <= 2'd0;
            r_crc         <= snpcr_pkg::CRC_INIT;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == snpcr_pkg::CFG_PAGE_BYTES) begin
                    r_page_bytes <= snpcr_pkg::clamp_len(i_cfg_wdata);
                end else begin
                    r_chunk_bytes <= snpcr_pkg::clamp_len(i_cfg_wdata);
                end
            end
            r_phase     <= n_phase;
            r_base      <= n_base;
            r_offset    <= n_offset;
            r_chunk_rem <= n_chunk_rem;
            r_hdr_idx   <= n_hdr_idx;
            r_crc       <= n_crc;
            r_wr_ptr    <= r_wr_ptr + QPTR'(push_cnt);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT'(push_cnt) - QCNT'(out_fire);
        end
    end

    // Queue entries carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + 1'b1] <= res1;
        end
    end

endmodule

`default_nettype wire

>>> sim/page_read_checker.sv
`timescale 1ns / 1ps

module page_read_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire                           i_in_ready,
    input  snpcr_pkg::t_in_item           i_in_item,
    input  wire                           i_out_valid,
    input  wire                           i_out_ready,
    input  snpcr_pkg::t_out_item          i_out_item,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_index,
    input  wire [snpcr_pkg::LEN_BITS-1:0] i_cfg_wdata,
    output logic                          o_seq_busy,
    output int                            o_pending,
    output int                            o_errors
);
    import snpcr_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_HEADER,
        SEQ_DATA
    } t_seq_phase;

    localparam logic [LEN_BITS-1:0]  LEN_CAP            = 17'h10000;
    localparam logic [LEN_BITS-1:0]  DEFAULT_PAGE_LEN   = 17'd4096;
    localparam logic [LEN_BITS-1:0]  DEFAULT_CHUNK_LEN  = 17'd128;
    localparam logic [31:0]          CRC_REFLECTED_POLY = 32'hEDB88320;
    localparam logic [31:0]          CRC_SEED           = 32'hFFFFFFFF;
    localparam logic [31:0]          CRC_FINAL_XOR      = 32'hFFFFFFFF;
    localparam logic [7:0]           READ_OPCODE        = 8'h03;
    localparam logic [7:0]           FILL_BYTE          = 8'hFF;

    logic [LEN_BITS-1:0]  page_len_reg;
    logic [LEN_BITS-1:0]  chunk_len_reg;
    t_seq_phase           seq_phase;
    logic [ADDR_BITS-1:0] page_base;
    logic [LEN_BITS-1:0]  bytes_done;
    logic [LEN_BITS-1:0]  chunk_left;
    logic [1:0]           header_pos;
    logic [31:0]          running_crc;
    t_out_item            results_due[$];

    // A length register of zero behaves as one; values past the cap saturate.
    function automatic logic [LEN_BITS-1:0] effective_len(input logic [LEN_BITS-1:0] raw);
        if (raw == '0) begin
            return 17'd1;
        end
        return (raw > LEN_CAP) ? LEN_CAP : raw;
    endfunction

    // Bit-serial form of the reflected CRC-32: each data bit enters the feedback.
    function automatic logic [31:0] crc_after_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ ({32{c[0] ^ b[k]}} & CRC_REFLECTED_POLY);
        end
        return c;
    endfunction

    function automatic int field_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want === got) begin
            return 0;
        end
        $display("%0t ns: result %s mismatch: expected %h, actual %h", $time, field, want, got);
        return 1;
    endfunction

    task automatic expect_result(input logic [1:0] act, input logic [7:0] tx,
                                 input logic [31:0] crc, input logic fin);
        t_out_item r;
        r.action     = act;
        r.tx_byte    = tx;
        r.crc_result = crc;
        r.last       = fin;
        results_due.push_back(r);
    endtask

    task automatic open_chunk();
        logic [LEN_BITS-1:0] page_len;
        logic [LEN_BITS-1:0] chunk_len;
        logic [LEN_BITS-1:0] room;
        page_len   = effective_len(page_len_reg);
        chunk_len  = effective_len(chunk_len_reg);
        room       = (bytes_done < page_len) ? page_len - bytes_done : 17'd1;
        chunk_left = (room < chunk_len) ? room : chunk_len;
        header_pos = 2'd0;
        seq_phase  = SEQ_HEADER;
    endtask

    task automatic advance_reader(input t_in_item req);
        logic [ADDR_BITS-1:0] flash_addr;
        if (req.opcode == OP_START) begin
            if (seq_phase == SEQ_IDLE) begin
                page_base   = req.page_address;
                bytes_done  = '0;
                running_crc = CRC_SEED;
                open_chunk();
                expect_result(ACT_XCHG, READ_OPCODE, '0, 1'b1);
            end
        end else if (seq_phase == SEQ_HEADER) begin
            if (header_pos != 2'd3) begin
                flash_addr = page_base + ADDR_BITS'(bytes_done);
                expect_result(ACT_XCHG, flash_addr[8 * (2 - header_pos) +: 8], '0, 1'b1);
                header_pos = header_pos + 2'd1;
            end else begin
                seq_phase = SEQ_DATA;
                expect_result(ACT_XCHG, FILL_BYTE, '0, 1'b1);
            end
        end else if (seq_phase == SEQ_DATA) begin
            running_crc = crc_after_byte(running_crc, req.rx_byte);
            if (bytes_done < LEN_CAP) begin
                bytes_done = bytes_done + 17'd1;
            end
            if (chunk_left != '0) begin
                chunk_left = chunk_left - 17'd1;
            end
            if (chunk_left != '0) begin
                expect_result(ACT_XCHG, FILL_BYTE, '0, 1'b1);
            end else begin
                expect_result(ACT_CS_HIGH, '0, '0, 1'b0);
                if (bytes_done >= effective_len(page_len_reg)) begin
                    expect_result(ACT_DONE, '0, running_crc ^ CRC_FINAL_XOR, 1'b1);
                    seq_phase  = SEQ_IDLE;
                    header_pos = 2'd0;
                end else begin
                    open_chunk();
                    expect_result(ACT_XCHG, READ_OPCODE, '0, 1'b1);
                end
            end
        end
    endtask

    // Results leave only after their request has been registered in the queue, so the
    // result side is checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        int        bad;
        if (!i_rst_n) begin
            page_len_reg  = DEFAULT_PAGE_LEN;
            chunk_len_reg = DEFAULT_CHUNK_LEN;
            seq_phase     = SEQ_IDLE;
            page_base     = '0;
            bytes_done    = '0;
            chunk_left    = '0;
            header_pos    = 2'd0;
            running_crc   = CRC_SEED;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PAGE_BYTES) begin
                    page_len_reg = i_cfg_wdata;
                end else begin
                    chunk_len_reg = i_cfg_wdata;
                end
            end
            if (i_out_valid === 1'b1 && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, actual %h",
                             $time, i_out_item);
                    o_errors++;
                end else begin
                    want = results_due.pop_front();
                    bad  = field_mismatch("action", 32'(want.action), 32'(i_out_item.action))
                         + field_mismatch("tx_byte", 32'(want.tx_byte), 32'(i_out_item.tx_byte))
                         + field_mismatch("crc_result", want.crc_result, i_out_item.crc_result)
                         + field_mismatch("last", 32'(want.last), 32'(i_out_item.last));
                    if (bad != 0) begin
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready === 1'b1) begin
                advance_reader(i_in_item);
            end
        end
        o_pending  = results_due.size();
        o_seq_busy = (seq_phase != SEQ_IDLE);
    end

endmodule

>>> sim/spi_nor_page_crc32_reader_tb.sv
`timescale 1ns / 1ps

module spi_nor_page_crc32_reader_tb;
    import snpcr_pkg::*;

    // Requests of the random part, counting only those that the reader acts on.
    localparam int RANDOM_REQUESTS = 1550;
    // Quiet cycles after the last expected result, in case an ignored request
    // is still inside the block.
    localparam int SETTLE_CYCLES   = 8;
    // Length of the long result-side hold that backs the block up.
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 5000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [LEN_BITS-1:0] i_cfg_wdata;

    logic seq_busy;
    int   pending;
    int   errors;

    // Shared between the request and result processes: whether random idle
    // bursts are enabled, and how many long holds have been asked for.
    bit   idle_on;
    int   holds_asked;
    int   request_count;

    spi_nor_page_crc32_reader DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // The checker follows both channels and the register port, keeps its own
    // copy of the sequencer, and hands back the predicted busy state, the
    // number of results still owed and the failure count.
    page_read_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_seq_busy  (seq_busy),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Generous bound on the whole run; a correct run ends long before it.
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side. Each pass is one falling edge and makes exactly one
    // assignment to the ready line. A long hold, when asked for, is counted
    // down here while the request side keeps offering requests.
    initial begin : result_side
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left  = 0;
        hold_left   = 0;
        holds_done  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Every field gets random content, the unused one of each opcode too.
    function automatic t_in_item random_item(input t_opcode op);
        t_in_item it;
        it.opcode       = op;
        it.page_address = 24'($urandom);
        it.rx_byte      = 8'($urandom);
        return it;
    endfunction

    // Page addresses lean toward both ends so that the 24-bit wrap is hit often.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        case ($urandom_range(0, 3))
            0: begin
                return 24'hFFFFFF - 24'($urandom_range(0, 64));
            end
            1: begin
                return 24'($urandom_range(0, 64));
            end
            default: begin
                return 24'($urandom);
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request
    // was taken. Valid is only lowered for an idle burst, never between two
    // back-to-back requests.
    task automatic send_request(input t_in_item req);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // One whole page: a start request, then one received byte for every
    // exchange until the predicted sequencer is back in idle. With noise on,
    // a received byte may come before the start and a second start may be
    // thrown in while the page is open; the block must ignore both.
    task automatic read_page(input logic [ADDR_BITS-1:0] addr, input bit noisy);
        t_in_item req;
        if (noisy && $urandom_range(0, 5) == 0) begin
            send_request(random_item(OP_RX));
        end
        req = random_item(OP_START);
        req.page_address = addr;
        send_request(req);
        request_count++;
        while (seq_busy) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                send_request(random_item(OP_START));
            end else begin
                send_request(random_item(OP_RX));
                request_count++;
            end
        end
    endtask

    // Registers may only change while the block is idle: stop offering,
    // wait for every owed result and then a few cycles more.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Both length registers are written, the page length first and then the chunk length.
    task automatic set_lengths(input logic [LEN_BITS-1:0] page_len,
                               input logic [LEN_BITS-1:0] chunk_len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PAGE_BYTES;
        i_cfg_wdata <= page_len;
        @(negedge i_clk);
        i_cfg_index <= CFG_CHUNK_BYTES;
        i_cfg_wdata <= chunk_len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic page_with(input logic [LEN_BITS-1:0] page_len,
                             input logic [LEN_BITS-1:0] chunk_len,
                             input logic [ADDR_BITS-1:0] addr);
        set_lengths(page_len, chunk_len);
        read_page(addr, 1'b0);
        settle();
    endtask

    initial begin : request_side
        t_in_item            req;
        logic [LEN_BITS-1:0] page_cfg;
        logic [LEN_BITS-1:0] chunk_cfg;
        int                  setting_no;
        int                  pages;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_PAGE_BYTES;
        i_cfg_wdata   = '0;
        idle_on       = 1'b1;
        holds_asked   = 0;
        request_count = 0;
        setting_no    = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Received bytes while idle are dropped, with both byte extremes.
        req = random_item(OP_RX);
        req.rx_byte = 8'h00;
        send_request(req);
        req = random_item(OP_RX);
        req.rx_byte = 8'hFF;
        send_request(req);

        // Only the page length is written, so the chunk length stays at the
        // value that reset loads. The second chunk's address wraps past the
        // top of the 24-bit space, and stray starts may arrive while the page is
        // open.
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PAGE_BYTES;
        i_cfg_wdata <= 17'd200;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        read_page(24'hFFFFC0, 1'b1);
        settle();

        // Shortest page, zero lengths read as one, a page whose last chunk is
        // short, and a chunk length above the cap.
        page_with(17'd1, 17'd1, 24'h000000);
        page_with(17'd0, 17'd0, 24'hFFFFFF);
        page_with(17'd5, 17'd2, 24'hA5A5A5);
        page_with(17'd3, 17'h1FFFF, 24'h5A5A5A);

        // Random part: a fresh pair of lengths every few pages, mostly short
        // pages, sometimes without any idling at all.
        request_count = 0;
        while (request_count < RANDOM_REQUESTS) begin
            idle_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    page_cfg  = '0;
                    chunk_cfg = 17'($urandom_range(0, 3));
                end
                1: begin
                    page_cfg  = 17'($urandom_range(1, 30));
                    chunk_cfg = ($urandom_range(0, 1) != 0) ? 17'h1FFFF : 17'h10000;
                end
                2: begin
                    page_cfg  = 17'($urandom_range(1, 12));
                    chunk_cfg = '0;
                end
                3: begin
                    page_cfg  = 17'($urandom_range(100, 400));
                    chunk_cfg = 17'($urandom_range(16, 96));
                end
                default: begin
                    page_cfg  = 17'($urandom_range(1, 40));
                    chunk_cfg = 17'($urandom_range(1, 48));
                end
            endcase
            set_lengths(page_cfg, chunk_cfg);
            // Now and then the result side holds off for a long time so that
            // the block's result queue fills and it stops taking requests.
            if (setting_no % 16 == 0) begin
                holds_asked++;
            end
            pages = $urandom_range(1, 4);
            for (int p = 0; p < pages && request_count < RANDOM_REQUESTS; p++) begin
                read_page(pick_address(), 1'b1);
            end
            settle();
            setting_no++;
        end

        // Last part, no idling on either side. A page of two chunks whose
        // second one starts past the address wrap, then a few short pages.
        idle_on = 1'b0;
        set_lengths(17'd60, 17'd40);
        read_page(24'hFFFFE0, 1'b0);
        settle();
        set_lengths(17'd7, 17'd3);
        repeat (3) read_page(pick_address(), 1'b1);

        i_in_valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/snpcr_pkg.sv
rtl/core/spi_nor_page_crc32_reader.sv
sim/page_read_checker.sv
sim/spi_nor_page_crc32_reader_tb.sv
